// File: hw/rtl/bldq_pkg.sv
// Shared types and codes of the bounded deque with linear search.
package bldq_pkg;

	// Operation codes carried in the command word.
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;

	// Status codes carried in the response word.
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef logic signed [31:0] elem_t;

	typedef struct packed {
		logic [2:0] operation;
		elem_t      value;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [5:0] position;
		logic [6:0] element_count;
		logic       list_empty;
	} rsp_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_REPLY
	} ctrl_state_t;

endpackage

// File: hw/rtl/bounded_list_deque_search_core.sv
// Top level of the bounded deque with linear search: sequencer, store and response register.
//
//   Channel  Handshake             Word        Use
//   cmd      cmd_valid/cmd_stall   cmd_word_t  one operation and its value
//   rsp      rsp_valid/rsp_stall   rsp_word_t  one result per command word
//
// A push or pop is accepted in S_IDLE: the command word is accepted, the store is written
// and pointers are updated in the same cycle, and the result is handed to the response
// register from S_REPLY once that register can take it. A search walks the store one
// element per cycle over the single read port and compares at most CAPACITY elements.
// Reset clears the pointer and count; the store needs no clearing since a
// search only reads slots a push has written. A full response register holds the result
// in S_REPLY, and no new command word is accepted until that result is handed off.
module bounded_list_deque_search_core #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  bldq_pkg::cmd_word_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bldq_pkg::rsp_word_t rsp
);
	import bldq_pkg::*;

	// Store index width and element count width (the count must reach CAPACITY).
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	elem_t         wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	elem_t         rd_data;

	logic          res_valid;
	logic          res_take;
	rsp_word_t     res;

	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	bldq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	bldq_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The response register takes a new result when it is empty or being drained.
	assign res_take  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

endmodule

// File: hw/rtl/bldq_store.sv
// Element store: one write port and one read port with registered read data.
module bldq_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  bldq_pkg::elem_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output bldq_pkg::elem_t rd_data
);
	import bldq_pkg::*;

	elem_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/bldq_ctrl.sv
// Sequencer: pointer and count update, store access, search walk and result build.
module bldq_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  bldq_pkg::cmd_word_t cmd,
	output logic                cmd_stall,
	output logic                res_valid,
	input  logic                res_take,
	output bldq_pkg::rsp_word_t res,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output bldq_pkg::elem_t     wr_data,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  bldq_pkg::elem_t     rd_data
);
	import bldq_pkg::*;

	localparam logic [AW:0]   CAP_W    = (AW+1)'(CAPACITY);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);

	ctrl_state_t state_q, state_d;

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	elem_t         key_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] idx_q;
	rsp_word_t     res_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW:0]   back_sum;
	logic [AW-1:0] back_slot;
	logic [AW-1:0] slot_inc;
	logic          idx_last;
	logic          hit;
	logic [1:0]    status_d;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign slot_inc  = (slot_q == LAST_IDX) ? '0 : slot_q + AW'(1);
	assign back_sum  = (AW+1)'(front_q) + (AW+1)'(count_q);
	assign back_slot = (back_sum >= CAP_W) ? AW'(back_sum - CAP_W) : AW'(back_sum);
	assign idx_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign hit       = (rd_data == key_q);
	assign wr_data   = cmd.value;
	assign res       = res_q;

	// Next pointer, count and status of an accepted command.
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = STAT_DONE;
		case (cmd.operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = back_slot;
		rd_en     = 1'b0;
		rd_addr   = slot_q;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_d = S_REPLY;
					case (cmd.operation)
						OP_PUSH_FRONT: begin
							wr_en   = !full;
							wr_addr = front_dec;
						end
						OP_PUSH_BACK: begin
							wr_en = !full;
						end
						OP_SEARCH: begin
							if (!empty) begin
								rd_en   = 1'b1;
								rd_addr = front_q;
								state_d = S_SEARCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				// Prefetch the next slot while the current element is compared.
				rd_en = 1'b1;
				if (hit || idx_last) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q               <= cmd.value;
			slot_q              <= front_inc;
			idx_q               <= '0;
			res_q.status        <= status_d;
			res_q.found         <= 1'b0;
			res_q.position      <= '0;
			res_q.element_count <= 7'(count_d);
			res_q.list_empty    <= (count_d == '0);
		end else if (state_q == S_SEARCH) begin
			slot_q <= slot_inc;
			idx_q  <= idx_q + AW'(1);
			if (hit) begin
				res_q.found    <= 1'b1;
				res_q.position <= 6'(idx_q);
			end
		end
	end

endmodule

// File: test/tb_bounded_list_deque_search_core.sv
// Self-checking testbench for the bounded deque with linear search.
`timescale 1ns / 100ps

module tb_bounded_list_deque_search_core;
	import bldq_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int DEPTH        = 64;
	// A search walks at most DEPTH elements, so the quiet stretch after the
	// last response is long enough to catch any stray word.
	localparam int DRAIN_CYCLES = 100;
	// The receiver hold-off is the longest legal silence on both channels; the
	// watchdog allows many times that before it gives up.
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 5000;

	// Codes 5 to 7 carry no operation; the block must answer them with the
	// unchanged count.
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

	localparam elem_t ELEM_MIN = 32'sh8000_0000;
	localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
	// Base of the distinct values used by the in-order fill.
	localparam elem_t FILL_TAG = 32'sh0001_0000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// Shadow of the list as the block should hold it after every accepted word.
	elem_t shadow_store [DEPTH];
	int    shadow_front = 0;
	int    shadow_count = 0;

	// Response words predicted for accepted command words, oldest first.
	rsp_word_t expected_rsp_q [$];

	int error_count   = 0;
	int idle_cycles   = 0;
	// Random gaps on both channels can be switched off for streaming stretches.
	bit gaps_on       = 1'b1;
	// The test side bumps hold_requests; the receiver starts a hold-off each
	// time it sees the count move.
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	bounded_list_deque_search_core #(
		.CAPACITY(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one command word to the shadow list and returns the response the
	// block must give for it. Refused pushes and pops leave the list alone.
	function automatic rsp_word_t predict_deque(input cmd_word_t w);
		rsp_word_t r;
		int        k;
		r = '0;
		case (w.operation)
			OP_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_store[shadow_front] = w.value;
					shadow_count++;
				end
			end
			OP_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_store[(shadow_front + shadow_count) % DEPTH] = w.value;
					shadow_count++;
				end
			end
			OP_POP_BACK: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else shadow_count--;
			end
			OP_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				// The lowest matching position wins, so stop at the first hit.
				for (k = 0; k < shadow_count && !r.found; k++) begin
					if (shadow_store[(shadow_front + k) % DEPTH] == w.value) begin
						r.found    = 1'b1;
						r.position = 6'(k);
					end
				end
			end
			default: ;
		endcase
		r.element_count = 7'(shadow_count);
		r.list_empty    = (shadow_count == 0);
		return r;
	endfunction

	// A value already held somewhere in the list; the caller makes sure the
	// list is not empty.
	function automatic elem_t pick_stored();
		return shadow_store[(shadow_front + $urandom_range(shadow_count - 1)) % DEPTH];
	endfunction

	// Values are a mix of full random words, a small pool that produces
	// duplicates, the extremes, and copies of held elements.
	function automatic elem_t pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35) return elem_t'($urandom);
		if (sel < 65) return elem_t'($urandom_range(8)) - 4;
		if (sel < 80) begin
			case ($urandom_range(3))
				0:       return ELEM_MIN;
				1:       return ELEM_MAX;
				2:       return 0;
				default: return -1;
			endcase
		end
		if (shadow_count > 0) return pick_stored();
		return elem_t'($urandom);
	endfunction

	// Search keys hit a held element about half the time.
	function automatic elem_t pick_key();
		if (shadow_count > 0 && $urandom_range(1) == 1) return pick_stored();
		return pick_value();
	endfunction

	// Offers one command word, holds it until the block takes it, and records
	// the predicted response. It returns at the accepting edge so that the next
	// word can follow back to back without valid dropping.
	task automatic send_word(input logic [2:0] op, input elem_t val);
		cmd_word_t w;
		w.operation = op;
		w.value     = val;
		if (gaps_on && $urandom_range(99) < 12) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		expected_rsp_q.push_back(predict_deque(w));
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_response(input rsp_word_t got);
		rsp_word_t want;
		if (expected_rsp_q.size() == 0) begin
			$display("%0t: response word with none expected, expected nothing, got %h",
				$time, got);
			error_count++;
		end else begin
			want = expected_rsp_q.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("found", 32'(want.found), 32'(got.found));
			compare_field("position", 32'(want.position), 32'(got.position));
			compare_field("element_count", 32'(want.element_count),
				32'(got.element_count));
			compare_field("list_empty", 32'(want.list_empty), 32'(got.list_empty));
		end
	endtask

	// Receiver: checks each accepted response word, then decides the stall for
	// the next cycle. Sampling happens before this edge's updates land, so the
	// stall value seen here is the one the block saw.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) check_response(rsp);
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= gaps_on && ($urandom_range(99) < 12);
		end
	end

	// Watchdog: a run that accepts nothing on either channel for too long is
	// hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("FAIL bounded_list_deque_search_core");
				$finish;
			end
		end
	end

	// Empty-list refusals, the unused codes, extreme values at both ends,
	// duplicate keys and a miss, then a walk back down to an empty list.
	task automatic test_directed_edges();
		send_word(OP_POP_BACK, elem_t'($urandom));
		send_word(OP_POP_FRONT, elem_t'($urandom));
		send_word(OP_SEARCH, 0);
		send_word(OP_FIRST_UNUSED, ELEM_MAX);
		send_word(3'(OP_FIRST_UNUSED + 1), ELEM_MIN);
		send_word(OP_LAST_UNUSED, -1);
		send_word(OP_PUSH_FRONT, ELEM_MIN);
		send_word(OP_PUSH_BACK, ELEM_MAX);
		send_word(OP_PUSH_FRONT, -1);
		send_word(OP_PUSH_BACK, 0);
		send_word(OP_PUSH_BACK, -1);
		// The list now reads -1, min, max, 0, -1 from the front.
		send_word(OP_SEARCH, -1);
		send_word(OP_SEARCH, ELEM_MAX);
		send_word(OP_SEARCH, 0);
		send_word(OP_SEARCH, 12345);
		send_word(OP_LAST_UNUSED, 0);
		send_word(OP_POP_BACK, 0);
		send_word(OP_POP_FRONT, 0);
		send_word(OP_SEARCH, -1);
		send_word(OP_SEARCH, ELEM_MIN);
		send_word(OP_POP_BACK, ELEM_MAX);
		send_word(OP_POP_BACK, ELEM_MIN);
		send_word(OP_POP_FRONT, -1);
		send_word(OP_POP_FRONT, 0);
	endtask

	// Fills the list to capacity, knocks on it when full, searches it, and
	// drains it to empty again. The first round fills in order with distinct
	// values so that a hit lands on the last position.
	task automatic test_fill_and_drain();
		for (int round = 0; round < 3; round++) begin
			while (shadow_count < DEPTH) begin
				if ($urandom_range(9) == 0) send_word(OP_SEARCH, pick_key());
				if (round == 0) send_word(OP_PUSH_BACK, FILL_TAG + elem_t'(shadow_count));
				else send_word($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
					pick_value());
			end
			send_word(OP_PUSH_FRONT, pick_value());
			send_word(OP_PUSH_BACK, pick_value());
			if (round == 0) begin
				send_word(OP_SEARCH, FILL_TAG + elem_t'(DEPTH - 1));
				send_word(OP_SEARCH, FILL_TAG);
			end
			repeat (4) send_word(OP_SEARCH, pick_key());
			while (shadow_count > 0) begin
				if ($urandom_range(9) == 0) send_word(OP_SEARCH, pick_key());
				send_word($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT,
					elem_t'($urandom));
			end
			send_word(OP_POP_FRONT, elem_t'($urandom));
			send_word(OP_POP_BACK, elem_t'($urandom));
		end
	endtask

	// Random traffic. The push/pop balance flips now and then so the list
	// swings between empty and full, and searches see every fill level.
	task automatic test_random_mix(input int n_items);
		int unsigned sel;
		bit          grow;
		logic [2:0]  op;
		grow = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(119) == 0) grow = ~grow;
			sel = $urandom_range(99);
			if (sel < 5) op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
			else if (sel < 35) op = OP_SEARCH;
			else if ($urandom_range(99) < (grow ? 70 : 30))
				op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
			send_word(op, (op == OP_SEARCH) ? pick_key() : pick_value());
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering words, so the block backs up and stalls its command side.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_requests++;
		test_random_mix(40);
		gaps_on = 1'b1;
	endtask

	// Back-to-back words and an always-ready receiver.
	task automatic test_streaming();
		gaps_on = 1'b0;
		test_random_mix(250);
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_edges();
		test_fill_and_drain();
		test_backpressure();
		test_random_mix(1050);
		test_streaming();
		cmd_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS bounded_list_deque_search_core");
		end else begin
			$display("FAIL bounded_list_deque_search_core");
		end
		$finish;
	end

endmodule
